// ----- rtl/vdi_pkg.sv -----
// Package for the vertex dedup indexer: sizes, beat structs, result kinds
// and the float order-key function. No dependencies.
`timescale 1ns / 1ps

package vdi_pkg;

    localparam int MAX_VERTICES  = 256;
    localparam int MAX_DIMENSION = 8;
    localparam int TRI_VERTS     = 3;

    localparam int VIDX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
    localparam int COMP_W  = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
    localparam int SADDR_W = VIDX_W + COMP_W;
    localparam int STORE_DEPTH = MAX_VERTICES * (1 << COMP_W);
    localparam int DIM_W   = 4;
    localparam int DCMP_W  = 5;
    localparam int TRI_W   = 2;

    localparam logic [1:0] KIND_COMP = 2'd0;
    localparam logic [1:0] KIND_IDX  = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd3;

    typedef struct packed {
        logic        req_type;
        logic [31:0] component_bits;
        logic        mesh_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       result_kind;
        logic [31:0]      result_value;
        logic             result_final;
        logic [CNT_W-1:0] unique_total;
        logic             error_flag;
    } out_item_t;

    typedef struct packed {
        logic lt;
        logic gt;
    } cmp_t;

    function automatic logic [31:0] order_key(input logic [31:0] b);
        logic [31:0] v;
        v = (b == 32'h8000_0000) ? 32'h0 : b;
        return v[31] ? ~v : (v | 32'h8000_0000);
    endfunction

endpackage

// ----- rtl/vertex_dedup_indexer.sv -----
// Vertex dedup indexer top level: load sequencer, ranking sequencer, drain.
// Depends on vdi_pkg, vdi_ram and vdi_cmp.
`timescale 1ns / 1ps
//
// Usage:
//   A command beat on request is taken when start is high and busy is low.
//   Loads (req_type 0) give no result and leave busy low. The load
//   with mesh_end set starts the ranking pass if any vertex is held, during which busy stays high:
//   a duplicate search over all earlier vertices, then a rank count over all
//   distinct vertices, each compare stepping one component at a time
//   through the vertex store read port (states S_CI, then S_CC).
//   Pulls (req_type 1) give exactly one result beat: done is high for one
//   cycle with the beat on result. A vertex component pull looks up rank
//   to representative to store, an element index pull the rank table,
//   a pull with nothing left none; busy is high until the beat shows.
//   The receiver cannot stall: each result beat is shown once only.
//   cfg_data sets vertex_dimension and empties the mesh when cfg_valid and cfg_ready
//   are high, unless a mesh is partly loaded; cfg_ready is high while the block is
//   idle and start is low. Reset empties the mesh, sets the dimension to 3 and
//   needs no clearing pass; the stores hold nothing meaningful until loaded.
//
module vertex_dedup_indexer
    import vdi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  in_item_t         request,
    output logic             done,
    output out_item_t        result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [DIM_W-1:0] cfg_data
);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_DRAIN = 4'd1;
    localparam logic [3:0] S_LDI   = 4'd2;
    localparam logic [3:0] S_LDIW  = 4'd3;
    localparam logic [3:0] S_JCHK  = 4'd4;
    localparam logic [3:0] S_CI    = 4'd5;
    localparam logic [3:0] S_CC    = 4'd6;
    localparam logic [3:0] S_IDONE = 4'd7;
    localparam logic [3:0] S_PREP  = 4'd8;
    localparam logic [3:0] S_PVAL  = 4'd9;
    localparam logic [3:0] S_PIDX  = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [DIM_W-1:0]  dim_reg, dim_next;
    logic [CNT_W-1:0]  vc_reg, vc_next;
    logic [COMP_W-1:0] cc_reg, cc_next;
    logic [TRI_W-1:0]  tri_reg, tri_next;
    logic [CNT_W-1:0]  distinct_reg, distinct_next;
    logic              fault_reg, fault_next;
    logic              pass_b_reg, pass_b_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [COMP_W-1:0] c_reg, c_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              found_reg, found_next;
    logic              cur_first_reg, cur_first_next;
    logic [CNT_W-1:0]  dr_rank_reg, dr_rank_next;
    logic [COMP_W-1:0] dr_comp_reg, dr_comp_next;
    logic [CNT_W-1:0]  dr_elem_reg, dr_elem_next;
    logic              done_reg, done_next;
    out_item_t         result_reg, result_next;
    logic [31:0]       vcache [MAX_DIMENSION];

    logic [DIM_W-1:0]  d_used;
    logic [DIM_W-1:0]  d_m1;
    logic              c_last;
    logic              cc_last;

    logic               st_we;
    logic [SADDR_W-1:0] st_waddr;
    logic [SADDR_W-1:0] st_raddr;
    logic [31:0]        st_rdata;
    logic               fr_we;
    logic               fr_wdata;
    logic [VIDX_W-1:0]  fr_raddr;
    logic               fr_rdata;
    logic               rk_we;
    logic [VIDX_W-1:0]  rk_rdata;
    logic               rp_we;
    logic [VIDX_W-1:0]  rp_rdata;
    cmp_t               cmp_res;

    logic [CNT_W-1:0]  vc_e;
    logic [COMP_W-1:0] cc_e;
    logic [TRI_W-1:0]  tri_e;
    logic              idle;

    always_comb
    begin
        if (dim_reg == '0)
        begin
            d_used = DIM_W'(1);
        end
        else if (DCMP_W'(dim_reg) > DCMP_W'(MAX_DIMENSION))
        begin
            d_used = DIM_W'(MAX_DIMENSION);
        end
        else
        begin
            d_used = dim_reg;
        end
    end

    assign d_m1    = d_used - DIM_W'(1);
    assign c_last  = DCMP_W'(c_reg) == DCMP_W'(d_m1);
    assign cc_last = DCMP_W'(cc_e) == DCMP_W'(d_m1);

    assign idle      = (state_reg == S_LOAD) || (state_reg == S_DRAIN);
    assign busy      = !idle;
    assign cfg_ready = idle && !start;
    assign done      = done_reg;
    assign result    = result_reg;

    assign vc_e  = (state_reg == S_DRAIN) ? '0 : vc_reg;
    assign cc_e  = (state_reg == S_DRAIN) ? '0 : cc_reg;
    assign tri_e = (state_reg == S_DRAIN) ? '0 : tri_reg;

    assign st_waddr = {vc_e[VIDX_W-1:0], cc_e};
    assign fr_raddr = (state_reg == S_LDI) ? i_reg[VIDX_W-1:0] : j_reg[VIDX_W-1:0];

    always_comb
    begin
        unique case (state_reg)
            S_LDI:   st_raddr = {i_reg[VIDX_W-1:0], c_reg};
            S_CI:    st_raddr = {j_reg[VIDX_W-1:0], c_reg};
            default: st_raddr = {rp_rdata, dr_comp_reg};
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        dim_next       = dim_reg;
        vc_next        = vc_reg;
        cc_next        = cc_reg;
        tri_next       = tri_reg;
        distinct_next  = distinct_reg;
        fault_next     = fault_reg;
        pass_b_next    = pass_b_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        c_next         = c_reg;
        cnt_next       = cnt_reg;
        found_next     = found_reg;
        cur_first_next = cur_first_reg;
        dr_rank_next   = dr_rank_reg;
        dr_comp_next   = dr_comp_reg;
        dr_elem_next   = dr_elem_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        st_we          = 1'b0;
        fr_we          = 1'b0;
        fr_wdata       = !found_reg;
        rk_we          = 1'b0;
        rp_we          = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            if (!(state_reg == S_LOAD && (vc_reg != '0 || cc_reg != '0)))
            begin
                dim_next      = cfg_data;
                vc_next       = '0;
                cc_next       = '0;
                tri_next      = '0;
                distinct_next = '0;
                fault_next    = 1'b0;
                dr_rank_next  = '0;
                dr_comp_next  = '0;
                dr_elem_next  = '0;
                state_next    = S_LOAD;
            end
        end
        else if (start && idle && !request.req_type)
        begin
            vc_next    = vc_e;
            cc_next    = cc_e;
            tri_next   = tri_e;
            state_next = S_LOAD;
            if (state_reg == S_DRAIN)
            begin
                distinct_next = '0;
                fault_next    = 1'b0;
            end
            if (vc_e == CNT_W'(MAX_VERTICES))
            begin
                fault_next = 1'b1;
            end
            else
            begin
                st_we = 1'b1;
                if (cc_last)
                begin
                    cc_next  = '0;
                    vc_next  = vc_e + CNT_W'(1);
                    tri_next = (tri_e == TRI_W'(TRI_VERTS - 1)) ? '0 : tri_e + TRI_W'(1);
                end
                else
                begin
                    cc_next = cc_e + COMP_W'(1);
                end
            end
            if (request.mesh_end)
            begin
                if (cc_next != '0)
                begin
                    fault_next = 1'b1;
                end
                if (tri_next != '0)
                begin
                    fault_next = 1'b1;
                end
                cc_next       = '0;
                vc_next       = vc_next - CNT_W'(tri_next);
                tri_next      = '0;
                distinct_next = '0;
                dr_rank_next  = '0;
                dr_comp_next  = '0;
                dr_elem_next  = '0;
                pass_b_next   = 1'b0;
                i_next        = '0;
                c_next        = '0;
                state_next    = (vc_next == '0) ? S_DRAIN : S_LDI;
            end
        end
        else if (start && idle && request.req_type)
        begin
            result_next.result_final = 1'b0;
            result_next.unique_total = distinct_reg;
            result_next.error_flag   = fault_reg;
            if (state_reg == S_DRAIN && dr_rank_reg < distinct_reg)
            begin
                state_next = S_PREP;
            end
            else if (state_reg == S_DRAIN && dr_elem_reg < vc_reg)
            begin
                state_next = S_PIDX;
            end
            else
            begin
                result_next.result_kind  = KIND_NONE;
                result_next.result_value = '0;
                done_next                = 1'b1;
            end
        end
        else
        begin
            unique case (state_reg)
                S_LDI:
                begin
                    state_next = S_LDIW;
                end
                S_LDIW:
                begin
                    cur_first_next = fr_rdata;
                    if (c_last)
                    begin
                        c_next     = '0;
                        j_next     = '0;
                        found_next = 1'b0;
                        cnt_next   = '0;
                        state_next = S_JCHK;
                    end
                    else
                    begin
                        c_next     = c_reg + COMP_W'(1);
                        state_next = S_LDI;
                    end
                end
                S_JCHK:
                begin
                    c_next = '0;
                    if (pass_b_reg ? (j_reg == vc_reg) : (j_reg == i_reg))
                    begin
                        state_next = S_IDONE;
                    end
                    else
                    begin
                        state_next = S_CI;
                    end
                end
                S_CI:
                begin
                    state_next = S_CC;
                end
                S_CC:
                begin
                    if (!pass_b_reg)
                    begin
                        if (!cmp_res.lt && !cmp_res.gt && c_last)
                        begin
                            found_next = 1'b1;
                            state_next = S_IDONE;
                        end
                        else if (!cmp_res.lt && !cmp_res.gt)
                        begin
                            c_next     = c_reg + COMP_W'(1);
                            state_next = S_CI;
                        end
                        else
                        begin
                            j_next     = j_reg + CNT_W'(1);
                            state_next = S_JCHK;
                        end
                    end
                    else
                    begin
                        if (!fr_rdata || cmp_res.gt || c_last || cmp_res.lt)
                        begin
                            if (fr_rdata && cmp_res.lt)
                            begin
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                            j_next     = j_reg + CNT_W'(1);
                            state_next = S_JCHK;
                        end
                        else
                        begin
                            c_next     = c_reg + COMP_W'(1);
                            state_next = S_CI;
                        end
                    end
                end
                S_IDONE:
                begin
                    if (!pass_b_reg)
                    begin
                        fr_we = 1'b1;
                    end
                    else
                    begin
                        rk_we = 1'b1;
                        if (cur_first_reg)
                        begin
                            rp_we         = 1'b1;
                            distinct_next = distinct_reg + CNT_W'(1);
                        end
                    end
                    c_next = '0;
                    if (i_reg + CNT_W'(1) == vc_reg)
                    begin
                        i_next = '0;
                        if (!pass_b_reg)
                        begin
                            pass_b_next = 1'b1;
                            state_next  = S_LDI;
                        end
                        else
                        begin
                            state_next = S_DRAIN;
                        end
                    end
                    else
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = S_LDI;
                    end
                end
                S_PREP:
                begin
                    state_next = S_PVAL;
                end
                S_PVAL:
                begin
                    result_next.result_kind  = KIND_COMP;
                    result_next.result_value = st_rdata;
                    done_next                = 1'b1;
                    if (DCMP_W'(dr_comp_reg) == DCMP_W'(d_m1))
                    begin
                        dr_comp_next = '0;
                        dr_rank_next = dr_rank_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dr_comp_next = dr_comp_reg + COMP_W'(1);
                    end
                    state_next = S_DRAIN;
                end
                S_PIDX:
                begin
                    result_next.result_kind  = KIND_IDX;
                    result_next.result_value = 32'(rk_rdata);
                    result_next.result_final = (dr_elem_reg + CNT_W'(1)) == vc_reg;
                    done_next                = 1'b1;
                    dr_elem_next             = dr_elem_reg + CNT_W'(1);
                    state_next               = S_DRAIN;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            dim_reg       <= DIM_RESET;
            vc_reg        <= '0;
            cc_reg        <= '0;
            tri_reg       <= '0;
            distinct_reg  <= '0;
            fault_reg     <= 1'b0;
            pass_b_reg    <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            c_reg         <= '0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            cur_first_reg <= 1'b0;
            dr_rank_reg   <= '0;
            dr_comp_reg   <= '0;
            dr_elem_reg   <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dim_reg       <= dim_next;
            vc_reg        <= vc_next;
            cc_reg        <= cc_next;
            tri_reg       <= tri_next;
            distinct_reg  <= distinct_next;
            fault_reg     <= fault_next;
            pass_b_reg    <= pass_b_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            c_reg         <= c_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            cur_first_reg <= cur_first_next;
            dr_rank_reg   <= dr_rank_next;
            dr_comp_reg   <= dr_comp_next;
            dr_elem_reg   <= dr_elem_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (state_reg == S_LDIW)
        begin
            vcache[c_reg] <= st_rdata;
        end
    end

    vdi_cmp u_cmp (
        .a   (st_rdata),
        .b   (vcache[c_reg]),
        .res (cmp_res)
    );

    vdi_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (request.component_bits),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    vdi_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_first (
        .clk   (clk),
        .we    (fr_we),
        .waddr (i_reg[VIDX_W-1:0]),
        .wdata (fr_wdata),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    vdi_ram #(.WIDTH(VIDX_W), .DEPTH(MAX_VERTICES)) u_rank (
        .clk   (clk),
        .we    (rk_we),
        .waddr (i_reg[VIDX_W-1:0]),
        .wdata (cnt_reg[VIDX_W-1:0]),
        .raddr (dr_elem_reg[VIDX_W-1:0]),
        .rdata (rk_rdata)
    );

    vdi_ram #(.WIDTH(VIDX_W), .DEPTH(MAX_VERTICES)) u_rep (
        .clk   (clk),
        .we    (rp_we),
        .waddr (cnt_reg[VIDX_W-1:0]),
        .wdata (i_reg[VIDX_W-1:0]),
        .raddr (dr_rank_reg[VIDX_W-1:0]),
        .rdata (rp_rdata)
    );

    a_comp_needs_unique: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.result_kind == KIND_COMP |-> result.unique_total != '0)
        else $error("component beat with no distinct vertices");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.result_kind == KIND_IDX
        |-> CNT_W'(result.result_value) < result.unique_total)
        else $error("element index beyond distinct count");

    a_final_on_index: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.result_final |-> result.result_kind == KIND_IDX)
        else $error("final mark on a non-index beat");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vc_reg <= CNT_W'(MAX_VERTICES) && distinct_reg <= vc_reg)
        else $error("vertex or distinct count out of range");

endmodule

// ----- rtl/vdi_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module vdi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/vdi_cmp.sv -----
// Component comparator: orders two float components as unsigned order keys, -0 equal to +0.
// Depends on vdi_pkg.
`timescale 1ns / 1ps

module vdi_cmp
    import vdi_pkg::*;
(
    input  logic [31:0] a,
    input  logic [31:0] b,
    output cmp_t        res
);

    logic [31:0] ka;
    logic [31:0] kb;

    assign ka     = order_key(a);
    assign kb     = order_key(b);
    assign res.lt = ka < kb;
    assign res.gt = ka > kb;

endmodule
